@@ hdl/vnfc_pkg.sv @@
// Shared types, constants and helpers for the voxel neighbor face cull block.
// No dependencies; imported by every module of the block.
package vnfc_pkg;

    localparam int DEF_MAX_X = 32;
    localparam int DEF_MAX_Y = 32;
    localparam int DEF_MAX_Z = 32;

    localparam int COORD_W   = 5;
    localparam int SIZE_W    = 6;
    localparam int EXT_W     = 9;   // holds a grid extent up to 511
    localparam int MASK_W    = 6;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int NB_IDX_W  = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
    localparam logic [MASK_W-1:0] FULL_MASK  = 6'h3F;

    // neighbor order, also the bit order of the masks
    localparam logic [NB_IDX_W-1:0] NB_FRONT  = 3'd0;
    localparam logic [NB_IDX_W-1:0] NB_BACK   = 3'd1;
    localparam logic [NB_IDX_W-1:0] NB_BOTTOM = 3'd2;
    localparam logic [NB_IDX_W-1:0] NB_TOP    = 3'd3;
    localparam logic [NB_IDX_W-1:0] NB_LEFT   = 3'd4;
    localparam logic [NB_IDX_W-1:0] NB_RIGHT  = 3'd5;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_CENTER,
        ST_NEIGH,
        ST_LAST,
        ST_DONE
    } seq_state_t;

    // active region, already saturated to the grid size
    typedef struct packed {
        logic [EXT_W-1:0] x;
        logic [EXT_W-1:0] y;
        logic [EXT_W-1:0] z;
    } ext_t;

    typedef struct packed {
        logic [MASK_W-1:0] nmask;
        logic [MASK_W-1:0] exposed;
        logic [CNT_W-1:0]  count;
        logic              oor;
    } result_t;

    function automatic logic [CNT_W-1:0] popcount6(input logic [MASK_W-1:0] v);
        logic [CNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < MASK_W; i++) begin
            acc = acc + CNT_W'(v[i]);
        end
        return acc;
    endfunction

endpackage

@@ hdl/voxel_neighbor_face_cull.sv @@
// Top level of the voxel neighbor face cull block: config, sequencer and
// output register. Depends on vnfc_pkg, vnfc_cfg and vnfc_seq.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata voxel coordinate + solid, s_tuser mode
//  m_       out  m_tvalid/m_tready    m_tdata masks + face count, m_tuser out_of_range
//  cfg_     in   cfg_valid/cfg_ready  cfg_addr register index, cfg_wdata size value
//
//  From accept, an out-of-range beat goes straight to its result, a write first
//  writes the grid, and a query reads the center voxel. The single-port grid
//  memory does one read per cycle: center first, then the neighbors in turn,
//  all six only for a solid center. After reset the grid is cleared, one voxel
//  a cycle; s_tready stays low meanwhile, config writes still go in.
//  A result waits in the output register while the next beat is taken; the
//  sequencer holds its finished result only while that register is full.
module voxel_neighbor_face_cull #(
    parameter int MAX_X = vnfc_pkg::DEF_MAX_X,
    parameter int MAX_Y = vnfc_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vnfc_pkg::DEF_MAX_Z
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,  // pos_x[4:0] pos_y[9:5] pos_z[14:10] solid[15]
    input  logic                           s_tuser,  // mode
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,  // neighbor_mask[5:0] exposed_faces[11:6]
                                                     // face_count[14:12] zero[15]
    output logic                           m_tuser,  // out_of_range
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vnfc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [vnfc_pkg::SIZE_W-1:0]    cfg_wdata
);
    import vnfc_pkg::*;

    ext_t    ext;
    result_t res;
    logic    res_valid, res_ready;

    logic    m_tvalid_reg;
    result_t m_res_reg;

    vnfc_cfg #(
        .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ext       (ext)
    );

    vnfc_seq #(
        .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ext       (ext),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_x      (s_tdata[4:0]),
        .in_y      (s_tdata[9:5]),
        .in_z      (s_tdata[14:10]),
        .in_solid  (s_tdata[15]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: loads when empty or draining this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) m_res_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg.count, m_res_reg.exposed, m_res_reg.nmask};
    assign m_tuser  = m_res_reg.oor;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("pending result changed before it was taken");
    a_load_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid)
        else $error("sequencer dropped a result while output register was full");
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("input taken while sequencer holds a result");
`endif

endmodule

@@ hdl/vnfc_cfg.sv @@
// Region size registers and their saturation to the grid dimensions.
// Depends on vnfc_pkg.
module vnfc_cfg #(
    parameter int MAX_X = vnfc_pkg::DEF_MAX_X,
    parameter int MAX_Y = vnfc_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vnfc_pkg::DEF_MAX_Z
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vnfc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [vnfc_pkg::SIZE_W-1:0]    cfg_wdata,
    output vnfc_pkg::ext_t                 ext
);
    import vnfc_pkg::*;

    localparam logic [EXT_W-1:0] LIM_X = EXT_W'(MAX_X);
    localparam logic [EXT_W-1:0] LIM_Y = EXT_W'(MAX_Y);
    localparam logic [EXT_W-1:0] LIM_Z = EXT_W'(MAX_Z);

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [EXT_W-1:0]  sx, sy, sz;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SIZE_X: size_x_reg <= cfg_wdata;
                CFG_SIZE_Y: size_y_reg <= cfg_wdata;
                CFG_SIZE_Z: size_z_reg <= cfg_wdata;
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    assign sx = EXT_W'(size_x_reg);
    assign sy = EXT_W'(size_y_reg);
    assign sz = EXT_W'(size_z_reg);

    assign ext.x = (sx > LIM_X) ? LIM_X : sx;
    assign ext.y = (sy > LIM_Y) ? LIM_Y : sy;
    assign ext.z = (sz > LIM_Z) ? LIM_Z : sz;

endmodule

@@ hdl/vnfc_seq.sv @@
// Occupancy memory with its clear pass and the read-modify sequencer that
// gathers the six neighbors of a query. Depends on vnfc_pkg.
module vnfc_seq #(
    parameter int MAX_X = vnfc_pkg::DEF_MAX_X,
    parameter int MAX_Y = vnfc_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vnfc_pkg::DEF_MAX_Z
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  vnfc_pkg::ext_t               ext,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_mode,
    input  logic [vnfc_pkg::COORD_W-1:0] in_x,
    input  logic [vnfc_pkg::COORD_W-1:0] in_y,
    input  logic [vnfc_pkg::COORD_W-1:0] in_z,
    input  logic                         in_solid,
    output logic                         res_valid,
    input  logic                         res_ready,
    output vnfc_pkg::result_t            res
);
    import vnfc_pkg::*;

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] STRIDE_X  = AW'(1);
    localparam logic [AW-1:0] STRIDE_Y  = AW'(MAX_X);
    localparam logic [AW-1:0] STRIDE_Z  = AW'(MAX_X * MAX_Y);

    logic grid [DEPTH];
    logic rdata_reg;

    seq_state_t          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       ctr_addr_reg;
    logic                solid_reg;
    logic [MASK_W-1:0]   nb_ok_reg;
    logic [NB_IDX_W-1:0] nb_idx_reg;
    logic [MASK_W-1:0]   nmask_reg;
    result_t             res_reg;

    logic          mem_en, mem_we, mem_wdata;
    logic [AW-1:0] mem_addr, nb_addr;
    logic          accept, oor_in;
    logic [MASK_W-1:0] ok_in, final_mask;
    logic [EXT_W-1:0]  ex_x, ex_y, ex_z;

    assign accept = in_valid && in_ready;
    assign ex_x   = EXT_W'(in_x);
    assign ex_y   = EXT_W'(in_y);
    assign ex_z   = EXT_W'(in_z);
    assign oor_in = (ex_x >= ext.x) || (ex_y >= ext.y) || (ex_z >= ext.z);

    always_comb begin
        ok_in            = '0;
        ok_in[NB_FRONT]  = (in_z != '0);
        ok_in[NB_BACK]   = ((ex_z + EXT_W'(1)) < ext.z);
        ok_in[NB_BOTTOM] = (in_y != '0);
        ok_in[NB_TOP]    = ((ex_y + EXT_W'(1)) < ext.y);
        ok_in[NB_LEFT]   = (in_x != '0);
        ok_in[NB_RIGHT]  = ((ex_x + EXT_W'(1)) < ext.x);
    end

    // neighbors outside the region read the center, the bit is masked later
    always_comb begin
        nb_addr = ctr_addr_reg;
        if (nb_ok_reg[nb_idx_reg]) begin
            case (nb_idx_reg)
                NB_FRONT:  nb_addr = ctr_addr_reg - STRIDE_Z;
                NB_BACK:   nb_addr = ctr_addr_reg + STRIDE_Z;
                NB_BOTTOM: nb_addr = ctr_addr_reg - STRIDE_Y;
                NB_TOP:    nb_addr = ctr_addr_reg + STRIDE_Y;
                NB_LEFT:   nb_addr = ctr_addr_reg - STRIDE_X;
                NB_RIGHT:  nb_addr = ctr_addr_reg + STRIDE_X;
                default:   nb_addr = ctr_addr_reg;
            endcase
        end
    end

    always_comb begin
        final_mask           = nmask_reg;
        final_mask[NB_RIGHT] = rdata_reg & nb_ok_reg[NB_RIGHT];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_addr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_valid) begin
                    if (oor_in)                    state_next = ST_DONE;
                    else if (in_mode == MODE_WRITE) state_next = ST_WRITE;
                    else                           state_next = ST_CENTER;
                end
            end
            ST_WRITE:  state_next = ST_DONE;
            ST_CENTER: state_next = ST_NEIGH;
            ST_NEIGH: begin
                if (nb_idx_reg == NB_FRONT && !rdata_reg) state_next = ST_DONE;
                else if (nb_idx_reg == NB_RIGHT)          state_next = ST_LAST;
            end
            ST_LAST:   state_next = ST_DONE;
            ST_DONE:   if (res_ready) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // outputs and memory port
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = ctr_addr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
            end
            ST_IDLE:   in_ready = 1'b1;
            ST_WRITE: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_wdata = solid_reg;
            end
            ST_CENTER: mem_en = 1'b1;
            ST_NEIGH: begin
                mem_en   = 1'b1;
                mem_addr = nb_addr;
            end
            ST_LAST:   ;
            ST_DONE:   res_valid = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_en) begin
            if (mem_we) grid[mem_addr] <= mem_wdata;
            else        rdata_reg      <= grid[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            solid_reg    <= in_solid;
            ctr_addr_reg <= AW'(in_x) + AW'(in_y) * STRIDE_Y + AW'(in_z) * STRIDE_Z;
            nb_ok_reg    <= ok_in;
            nb_idx_reg   <= NB_FRONT;
            nmask_reg    <= '0;
            res_reg      <= '{nmask: '0, exposed: '0, count: '0, oor: oor_in};
        end
        if (state_reg == ST_NEIGH) begin
            nb_idx_reg <= nb_idx_reg + NB_IDX_W'(1);
            if (nb_idx_reg == NB_FRONT) begin
                // first data back is the center voxel
                if (!rdata_reg) res_reg <= '{nmask: FULL_MASK, exposed: '0, count: '0, oor: 1'b0};
            end else begin
                nmask_reg[nb_idx_reg - NB_IDX_W'(1)] <=
                    rdata_reg & nb_ok_reg[nb_idx_reg - NB_IDX_W'(1)];
            end
        end
        if (state_reg == ST_LAST) begin
            res_reg <= '{nmask: final_mask, exposed: ~final_mask,
                         count: popcount6(~final_mask), oor: 1'b0};
        end
    end

    assign res = res_reg;

`ifndef ASSERT_OFF
    a_oor_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && oor_in |=> state_reg == ST_DONE && res_reg.oor)
        else $error("out-of-range item did not go straight to result");
    a_exposed_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (res.exposed & res.nmask) == '0)
        else $error("exposed faces overlap neighbor mask");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res.count == CNT_W'($countones(res.exposed)))
        else $error("face count disagrees with exposed mask");
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.oor |-> res.nmask == '0 && res.count == '0)
        else $error("out-of-range result carries mask data");
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == ST_CLEAR || state_reg == ST_WRITE)
        else $error("grid written outside clear or write step");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for voxel_neighbor_face_cull: write and query beats with a shadow grid
// that predicts every result beat. Depends on vnfc_pkg and the voxel_neighbor_face_cull RTL.
module testbench;
    import vnfc_pkg::*;

    localparam int GRID_X          = DEF_MAX_X;
    localparam int GRID_Y          = DEF_MAX_Y;
    localparam int GRID_Z          = DEF_MAX_Z;
    localparam int WATCHDOG_CYCLES = 100000;   // covers the post-reset grid clear
    localparam int SETTLE_CYCLES   = 12;       // slowest beat is a solid query
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped register index

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_BURSTY
    } rx_pattern_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;    // pos_x[4:0] pos_y[9:5] pos_z[14:10] solid[15]
    logic                 s_tuser;    // mode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;    // neighbor_mask[5:0] exposed_faces[11:6] face_count[14:12]
    logic                 m_tuser;    // out_of_range
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [SIZE_W-1:0]    cfg_wdata;

    // shadow of the block: region registers, saturated extents, occupancy
    logic [SIZE_W-1:0] size_x_reg = SIZE_RESET;
    logic [SIZE_W-1:0] size_y_reg = SIZE_RESET;
    logic [SIZE_W-1:0] size_z_reg = SIZE_RESET;
    int ext_x = GRID_X;
    int ext_y = GRID_Y;
    int ext_z = GRID_Z;
    bit grid [GRID_X*GRID_Y*GRID_Z];

    result_t voxel_results[$];   // expected result beats, oldest first
    int fail_count   = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;
    bit steady_send  = 1'b0;

    rx_pattern_t rx_mode = RX_OPEN;
    int rx_left = 0;
    int rx_hold = 0;

    voxel_neighbor_face_cull dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- prediction

    // Solid test for a neighbor; anything outside the active region reads empty.
    function automatic bit occupied(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x >= ext_x || y >= ext_y || z >= ext_z) return 1'b0;
        return grid[x + y*GRID_X + z*GRID_X*GRID_Y];
    endfunction

    // Applies one beat to the shadow grid and returns the result beat it causes.
    function automatic result_t cull_predict(input logic mode, input logic [4:0] x, y, z,
                                             input logic solid);
        result_t r;
        int xi, yi, zi, vox_idx;
        r  = '0;
        xi = x;
        yi = y;
        zi = z;
        vox_idx = xi + yi*GRID_X + zi*GRID_X*GRID_Y;
        if (xi >= ext_x || yi >= ext_y || zi >= ext_z) begin
            r.oor = 1'b1;                     // ignored, masks stay zero
        end else if (mode == MODE_WRITE) begin
            grid[vox_idx] = solid;
        end else if (!grid[vox_idx]) begin
            r.nmask = FULL_MASK;              // empty voxel: nothing to draw
        end else begin
            r.nmask[NB_FRONT]  = occupied(xi, yi, zi - 1);
            r.nmask[NB_BACK]   = occupied(xi, yi, zi + 1);
            r.nmask[NB_BOTTOM] = occupied(xi, yi - 1, zi);
            r.nmask[NB_TOP]    = occupied(xi, yi + 1, zi);
            r.nmask[NB_LEFT]   = occupied(xi - 1, yi, zi);
            r.nmask[NB_RIGHT]  = occupied(xi + 1, yi, zi);
            r.exposed = ~r.nmask;
            r.count   = CNT_W'($countones(r.exposed));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // One input beat. Entered and left at a falling edge; the prediction is
    // taken at the accepting rising edge so it follows the block's order.
    task automatic send_op(input logic mode, input logic [4:0] x, y, z, input logic solid);
        int gap;
        result_t want_beat;
        s_tuser  = mode;
        s_tdata  = {solid, z, y, x};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want_beat = cull_predict(mode, x, y, z, solid);
        voxel_results.insert(voxel_results.size(), want_beat);
        @(negedge aclk);
        s_tvalid = 1'b0;
        // bursts of random length, random gaps between them
        if (burst_left > 0) begin
            burst_left--;
        end else if (!steady_send) begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Wait until every expected beat has come, then let the extra idle cycles pass.
    task automatic settle(input int extra);
        while (voxel_results.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_addr  = idx;
        cfg_wdata = val;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_SIZE_X: size_x_reg = val;
            CFG_SIZE_Y: size_y_reg = val;
            CFG_SIZE_Z: size_z_reg = val;
            default: ;                        // unmapped index changes nothing
        endcase
        ext_x = (size_x_reg > GRID_X) ? GRID_X : size_x_reg;
        ext_y = (size_y_reg > GRID_Y) ? GRID_Y : size_y_reg;
        ext_z = (size_z_reg > GRID_Z) ? GRID_Z : size_z_reg;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Region change, only with the block idle.
    task automatic set_region(input logic [SIZE_W-1:0] sx, sy, sz);
        settle(SETTLE_CYCLES);
        write_size(CFG_SIZE_X, sx);
        write_size(CFG_SIZE_Y, sy);
        write_size(CFG_SIZE_Z, sz);
    endtask

    // ---------------------------------------------------------------- tests

    // Full 32^3 region: empty query, isolated corner voxel with three neighbors off
    // the grid, fully enclosed voxel, clearing a voxel.
    task automatic test_open_grid();
        send_op(MODE_QUERY, 0, 0, 0, 0);      // empty -> full mask, no faces
        send_op(MODE_WRITE, 0, 0, 0, 1);
        send_op(MODE_QUERY, 0, 0, 0, 0);      // corner, six faces
        send_op(MODE_WRITE, 5, 5, 4, 1);
        send_op(MODE_WRITE, 5, 5, 6, 1);
        send_op(MODE_WRITE, 5, 4, 5, 1);
        send_op(MODE_WRITE, 5, 6, 5, 1);
        send_op(MODE_WRITE, 4, 5, 5, 1);
        send_op(MODE_WRITE, 6, 5, 5, 1);
        send_op(MODE_WRITE, 5, 5, 5, 1);
        send_op(MODE_QUERY, 5, 5, 5, 1);      // enclosed -> no faces
        send_op(MODE_WRITE, 5, 5, 6, 0);      // clear the back neighbor
        send_op(MODE_QUERY, 5, 5, 5, 0);
    endtask

    // Region edges, out-of-range on each axis, zero size, saturated size,
    // single-voxel region and a write to the unmapped index.
    task automatic test_region_limits();
        // stored voxels just past the far faces of the small region below, and one inside it
        send_op(MODE_WRITE, 4, 2, 1, 1);
        send_op(MODE_WRITE, 3, 2, 2, 1);
        send_op(MODE_WRITE, 2, 2, 1, 1);
        set_region(4, 3, 2);
        send_op(MODE_WRITE, 3, 2, 1, 1);
        send_op(MODE_QUERY, 3, 2, 1, 0);      // right, top and back lie outside the region
        send_op(MODE_WRITE, 4, 0, 0, 1);      // x out of range
        send_op(MODE_QUERY, 0, 3, 0, 0);      // y out of range
        send_op(MODE_WRITE, 0, 0, 2, 1);      // z out of range
        set_region(0, 32, 32);
        send_op(MODE_QUERY, 0, 0, 0, 0);      // zero size: nothing is in range
        send_op(MODE_WRITE, 0, 0, 0, 0);      // ignored, voxel stays solid
        set_region(63, 63, 63);               // saturates to the grid
        send_op(MODE_QUERY, 31, 31, 31, 1);
        set_region(1, 1, 1);
        send_op(MODE_QUERY, 0, 0, 0, 1);
        settle(SETTLE_CYCLES);
        write_size(CFG_SPARE, 0);
        send_op(MODE_QUERY, 0, 0, 0, 0);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        if ($urandom_range(0, 7) != 0) return SIZE_W'($urandom_range(1, 32));
        return $urandom_range(0, 1) ? SIZE_W'(0) : SIZE_W'($urandom_range(33, 63));
    endfunction

    // Coordinate inside a 4-wide cluster so that neighbors actually fill in.
    function automatic logic [4:0] near_coord(input int ext, input int base);
        int span;
        span = (ext < 4) ? ext : 4;
        if (span == 0) return 5'($urandom);
        return 5'(base + $urandom_range(0, span - 1));
    endfunction

    // Phases of clustered writes and queries with some noise beats.
    task automatic test_random_traffic();
        int phase, n, bx, by, bz;
        logic mode, solid;
        logic [4:0] x, y, z;
        bx = 0;
        by = 0;
        bz = 0;
        for (phase = 0; phase < 5; phase++) begin
            if (phase == 0)
                set_region(32, 32, 32);
            else if (phase == 4)
                set_region(2, 3, 2);
            else
                set_region(pick_size(), pick_size(), pick_size());
            steady_send = (phase == 2);
            for (n = 0; n < 110; n++) begin
                if (n % 32 == 0) begin
                    bx = (ext_x > 4) ? $urandom_range(0, ext_x - 4) : 0;
                    by = (ext_y > 4) ? $urandom_range(0, ext_y - 4) : 0;
                    bz = (ext_z > 4) ? $urandom_range(0, ext_z - 4) : 0;
                end
                if (n == 55) settle(0);       // let the result side run dry
                mode  = ($urandom_range(0, 9) < 4) ? MODE_QUERY : MODE_WRITE;
                solid = ($urandom_range(0, 9) < 7);
                if ($urandom_range(0, 9) == 0) begin
                    x = 5'($urandom);
                    y = 5'($urandom);
                    z = 5'($urandom);
                end else begin
                    x = near_coord(ext_x, bx);
                    y = near_coord(ext_y, by);
                    z = near_coord(ext_z, bz);
                end
                send_op(mode, x, y, z, solid);
            end
        end
        steady_send = 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    // Stall pattern of the receiver, picked at random again whenever its run ends.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_left == 0) begin
                rx_mode = rx_pattern_t'($urandom_range(0, 3));
                rx_left = $urandom_range(40, 160);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:   m_tready = 1'b1;
                RX_RANDOM: m_tready = ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_tready = (rx_left % 4 == 0);
                default: begin
                    if (rx_hold > 0) begin
                        rx_hold--;
                        m_tready = 1'b0;
                    end else begin
                        m_tready = 1'b1;
                        if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(5, 30);
                    end
                end
            endcase
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (voxel_results.size() == 0) begin
                $error("result beat with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = voxel_results.pop_front();
                if (m_tdata[5:0] !== want.nmask) begin
                    $error("neighbor_mask: expected %h, got %h", want.nmask, m_tdata[5:0]);
                    fail_count++;
                end
                if (m_tdata[11:6] !== want.exposed) begin
                    $error("exposed_faces: expected %h, got %h", want.exposed, m_tdata[11:6]);
                    fail_count++;
                end
                if (m_tdata[14:12] !== want.count) begin
                    $error("face_count: expected %0d, got %0d", want.count, m_tdata[14:12]);
                    fail_count++;
                end
                if (m_tuser !== want.oor) begin
                    $error("out_of_range: expected %b, got %b", want.oor, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Ends a hung run: too many cycles without any beat on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("voxel_neighbor_face_cull: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_WRITE;
        cfg_valid = 1'b0;
        cfg_addr  = CFG_SIZE_X;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_open_grid();
        test_region_limits();
        test_random_traffic();

        settle(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("voxel_neighbor_face_cull: match");
        else
            $display("voxel_neighbor_face_cull: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/vnfc_pkg.sv
hdl/vnfc_cfg.sv
hdl/vnfc_seq.sv
hdl/voxel_neighbor_face_cull.sv
sim/testbench.sv
